// ===== design/rgfa_pkg.sv =====
// Shared types, field widths and codes of the ready-gated FIFO grant arbiter.
package rgfa_pkg;

   // Fixed widths of the request and response fields.
   localparam int QID_W    = 4;
   localparam int KIND_W   = 2;
   localparam int STATUS_W = 3;
   localparam int PKT_W    = 2;

   // Barrier packets reported ahead of a serialized dispatch.
   localparam logic [PKT_W-1:0] BARRIER_PACKETS = PKT_W'(3);

   // Default sizing of the arbiter.
   localparam int NUM_QUEUES_DEF      = 16;
   localparam int FIFO_DEPTH_DEF      = 32;
   localparam int READY_COUNT_MAX_DEF = 63;

   typedef enum logic [KIND_W-1:0] {
      KIND_DISPATCH = 2'd0,
      KIND_READY    = 2'd1,
      KIND_COMPLETE = 2'd2,
      KIND_DESTROY  = 2'd3
   } kind_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK              = 3'd0,
      ST_FULL            = 3'd1,
      ST_NO_OWNER        = 3'd2,
      ST_DESTROY_OWNING  = 3'd3,
      ST_DESTROY_PENDING = 3'd4
   } status_type;

   // Command from the sequencer to the pending queue engine.
   typedef struct packed {
      logic             append;
      logic             search;
      logic             grant_mode;
      logic [QID_W-1:0] qid;
   } pend_cmd_type;

   // Status from the pending queue engine back to the sequencer.
   typedef struct packed {
      logic             done;
      logic             found;
      logic [QID_W-1:0] found_q;
      logic             full;
   } pend_stat_type;

endpackage

// ===== design/rgfa_pend.sv =====
// Pending queue store with an entry-by-entry search and compaction engine.
module rgfa_pend #(
   parameter int NUM_QUEUES = rgfa_pkg::NUM_QUEUES_DEF,
   parameter int FIFO_DEPTH = rgfa_pkg::FIFO_DEPTH_DEF
) (
   input  logic                    clock,
   input  logic                    reset,
   input  rgfa_pkg::pend_cmd_type  pend_cmd,
   input  logic [NUM_QUEUES-1:0]   ready_nz,
   output rgfa_pkg::pend_stat_type pend_stat
);
   import rgfa_pkg::*;

   localparam int AW     = $clog2(FIFO_DEPTH);
   localparam int CNT_W  = $clog2(FIFO_DEPTH + 1);
   localparam int QIDX_W = $clog2(NUM_QUEUES);
   localparam int QEXT_W = (QIDX_W > QID_W) ? QIDX_W : QID_W;

   typedef enum logic [2:0] {
      E_IDLE  = 3'b001,
      E_SCAN  = 3'b010,
      E_SHIFT = 3'b100
   } eng_state_type;

   eng_state_type      state_ff, state_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   logic [CNT_W-1:0]   ptr_ff, ptr_in;
   logic [CNT_W-1:0]   pos_ff, pos_in;
   logic               chk_vld_ff, chk_vld_in;
   logic               mode_ff, mode_in;
   logic [QID_W-1:0]   key_ff, key_in;
   logic               wr_vld_ff, wr_vld_in;
   logic [AW-1:0]      wr_addr_ff, wr_addr_in;
   logic [QID_W-1:0]   found_q_ff, found_q_in;
   logic               found_ff, found_in;
   logic               done_ff, done_in;

   logic [QID_W-1:0]   mem_ff [FIFO_DEPTH];
   logic [QID_W-1:0]   rd_data_ff;
   logic               mem_re, mem_we;
   logic [AW-1:0]      mem_raddr, mem_waddr;
   logic [QID_W-1:0]   mem_wdata;

   logic [QEXT_W-1:0]  rd_ext;
   logic [CNT_W-1:0]   ptr_m1;
   logic               full;
   logic               hit;

   assign full   = (cnt_ff == CNT_W'(FIFO_DEPTH));
   assign rd_ext = QEXT_W'(rd_data_ff);
   assign ptr_m1 = ptr_ff - CNT_W'(1);
   // A grant search looks for a queue with a nonzero ready count, a purge for the key.
   assign hit = chk_vld_ff &&
                (mode_ff ? ready_nz[rd_ext[QIDX_W-1:0]] : (rd_data_ff == key_ff));

   always_comb begin
      state_in   = state_ff;
      cnt_in     = cnt_ff;
      ptr_in     = ptr_ff;
      pos_in     = pos_ff;
      chk_vld_in = 1'b0;
      mode_in    = mode_ff;
      key_in     = key_ff;
      wr_vld_in  = 1'b0;
      wr_addr_in = wr_addr_ff;
      found_q_in = found_q_ff;
      found_in   = found_ff;
      done_in    = 1'b0;
      mem_re     = 1'b0;
      mem_raddr  = ptr_ff[AW-1:0];
      mem_we     = 1'b0;
      mem_waddr  = wr_addr_ff;
      mem_wdata  = rd_data_ff;
      unique case (state_ff)
         E_IDLE: begin
            if (pend_cmd.append && !full) begin
               mem_we    = 1'b1;
               mem_waddr = cnt_ff[AW-1:0];
               mem_wdata = pend_cmd.qid;
               cnt_in    = cnt_ff + CNT_W'(1);
            end
            if (pend_cmd.search) begin
               mode_in  = pend_cmd.grant_mode;
               key_in   = pend_cmd.qid;
               ptr_in   = '0;
               state_in = E_SCAN;
            end
         end
         E_SCAN: begin
            if (hit) begin
               found_q_in = rd_data_ff;
               ptr_in     = pos_ff + CNT_W'(1);
               state_in   = E_SHIFT;
            end else if (ptr_ff < cnt_ff) begin
               mem_re     = 1'b1;
               chk_vld_in = 1'b1;
               pos_in     = ptr_ff;
               ptr_in     = ptr_ff + CNT_W'(1);
            end else begin
               found_in = 1'b0;
               done_in  = 1'b1;
               state_in = E_IDLE;
            end
         end
         E_SHIFT: begin
            // Each entry behind the removed one moves down by one place.
            mem_we = wr_vld_ff;
            if (ptr_ff < cnt_ff) begin
               mem_re     = 1'b1;
               wr_vld_in  = 1'b1;
               wr_addr_in = ptr_m1[AW-1:0];
               ptr_in     = ptr_ff + CNT_W'(1);
            end else begin
               cnt_in   = cnt_ff - CNT_W'(1);
               found_in = 1'b1;
               done_in  = 1'b1;
               state_in = E_IDLE;
            end
         end
         default: begin
            state_in = E_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem_ff[mem_waddr] <= mem_wdata;
      end
      if (mem_re) begin
         rd_data_ff <= mem_ff[mem_raddr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= E_IDLE;
         cnt_ff     <= '0;
         chk_vld_ff <= 1'b0;
         wr_vld_ff  <= 1'b0;
         done_ff    <= 1'b0;
      end else begin
         state_ff   <= state_in;
         cnt_ff     <= cnt_in;
         chk_vld_ff <= chk_vld_in;
         wr_vld_ff  <= wr_vld_in;
         done_ff    <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      ptr_ff     <= ptr_in;
      pos_ff     <= pos_in;
      mode_ff    <= mode_in;
      key_ff     <= key_in;
      wr_addr_ff <= wr_addr_in;
      found_q_ff <= found_q_in;
      found_ff   <= found_in;
   end

   assign pend_stat.done    = done_ff;
   assign pend_stat.found   = found_ff;
   assign pend_stat.found_q = found_q_ff;
   assign pend_stat.full    = full;

endmodule

// ===== design/ready_gated_fifo_grant_arbiter.sv =====
// Top level of the ready-gated FIFO grant arbiter: sequencer, ready counts and response.
// Dispatch, disabled and out-of-range requests pass through decode to the response state;
// the next request can be taken in the cycle after the response is loaded.
// A ready request also passes through the ready-count memory read and write states.
// Grants and purges scan the pending FIFO one entry a cycle and then compact it.
// One request is in work at a time; synchronous reset clears owner, seen map and counts at once.
module ready_gated_fifo_grant_arbiter #(
   parameter int NUM_QUEUES      = rgfa_pkg::NUM_QUEUES_DEF,
   parameter int FIFO_DEPTH      = rgfa_pkg::FIFO_DEPTH_DEF,
   parameter int READY_COUNT_MAX = rgfa_pkg::READY_COUNT_MAX_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   // Configuration register.
   input  logic                          csr_wr_en,
   input  logic                          csr_wr_data,
   // Request channel.
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [rgfa_pkg::KIND_W-1:0]   req_kind,
   input  logic [rgfa_pkg::QID_W-1:0]    req_queue_id,
   // Response channel.
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [rgfa_pkg::STATUS_W-1:0] rsp_status,
   output logic                          rsp_granted,
   output logic [rgfa_pkg::QID_W-1:0]    rsp_granted_queue,
   output logic                          rsp_blocked,
   output logic                          rsp_unblock_destroyed,
   output logic [rgfa_pkg::PKT_W-1:0]    rsp_packet_count,
   output logic                          rsp_new_queue,
   output logic                          rsp_owner_valid,
   output logic [rgfa_pkg::QID_W-1:0]    rsp_owner_queue
);
   import rgfa_pkg::*;

   localparam int QIDX_W = $clog2(NUM_QUEUES);
   localparam int QEXT_W = (QIDX_W > QID_W) ? QIDX_W : QID_W;
   localparam int RC_W   = $clog2(READY_COUNT_MAX + 1);
   localparam logic [RC_W-1:0] RC_MAX = RC_W'(READY_COUNT_MAX);

   // The sequencer walks each request through decode and, as its kind needs, the ready-count memory and the
   // pending-FIFO engine, and finally hands the result to the response register.
   typedef enum logic [7:0] {
      S_IDLE   = 8'b0000_0001,
      S_DECODE = 8'b0000_0010,
      S_RC_RD  = 8'b0000_0100,
      S_RC_WR  = 8'b0000_1000,
      S_SEARCH = 8'b0001_0000,
      S_DEC_RD = 8'b0010_0000,
      S_DEC_WR = 8'b0100_0000,
      S_RESP   = 8'b1000_0000
   } seq_state_type;

   seq_state_type       state_ff, state_in;
   logic                enable_ff;

   // Request being worked on and its result as it builds up.
   kind_type            kind_ff, kind_in;
   logic [QID_W-1:0]    q_ff, q_in;
   status_type          status_ff, status_in;
   logic                granted_ff, granted_in;
   logic [QID_W-1:0]    gq_ff, gq_in;
   logic                blocked_ff, blocked_in;
   logic                unblock_ff, unblock_in;
   logic [PKT_W-1:0]    pkt_ff, pkt_in;
   logic                new_ff, new_in;

   // Arbitration state.
   logic                owner_vld_ff, owner_vld_in;
   logic [QID_W-1:0]    owner_id_ff, owner_id_in;
   logic [NUM_QUEUES-1:0] seen_ff, seen_in;
   // A queue's ready count is nonzero exactly when its bit here is set. A clear bit
   // means a count of zero whatever the memory holds, so reset and destroy need no sweep.
   logic [NUM_QUEUES-1:0] nz_ff, nz_in;

   // Ready-count memory, one port, registered read.
   logic [RC_W-1:0]     rc_mem_ff [NUM_QUEUES];
   logic [RC_W-1:0]     rc_rd_ff;
   logic                rc_re, rc_we;
   logic [QIDX_W-1:0]   rc_addr;
   logic [RC_W-1:0]     rc_wdata;
   logic [RC_W-1:0]     rc_cur;

   // Response register.
   logic                rsp_valid_ff, rsp_valid_in;
   logic                load_rsp;
   status_type          rsp_status_ff;
   logic                rsp_granted_ff;
   logic [QID_W-1:0]    rsp_gq_ff;
   logic                rsp_blocked_ff;
   logic                rsp_unblock_ff;
   logic [PKT_W-1:0]    rsp_pkt_ff;
   logic                rsp_new_ff;
   logic                rsp_owner_vld_ff;
   logic [QID_W-1:0]    rsp_owner_id_ff;

   pend_cmd_type        pend_cmd;
   pend_stat_type       pend_stat;

   logic                req_accept;
   logic [QEXT_W-1:0]   q_ext;
   logic [QEXT_W-1:0]   gq_ext;
   logic                in_range;
   logic [QIDX_W-1:0]   qidx;
   logic [QIDX_W-1:0]   gidx;

   assign req_stall  = (state_ff != S_IDLE);
   assign req_accept = req_valid && !req_stall;

   // Queue ids at or above NUM_QUEUES are answered but change no state.
   assign q_ext    = QEXT_W'(q_ff);
   assign gq_ext   = QEXT_W'(gq_ff);
   assign in_range = ({1'b0, q_ext} < (QEXT_W + 1)'(NUM_QUEUES));
   assign qidx     = q_ext[QIDX_W-1:0];
   assign gidx     = gq_ext[QIDX_W-1:0];
   assign rc_cur   = nz_ff[qidx] ? rc_rd_ff : '0;

   rgfa_pend #(
      .NUM_QUEUES (NUM_QUEUES),
      .FIFO_DEPTH (FIFO_DEPTH)
   ) u_pend (
      .clock     (clock),
      .reset     (reset),
      .pend_cmd  (pend_cmd),
      .ready_nz  (nz_ff),
      .pend_stat (pend_stat)
   );

   always_comb begin
      state_in     = state_ff;
      kind_in      = kind_ff;
      q_in         = q_ff;
      status_in    = status_ff;
      granted_in   = granted_ff;
      gq_in        = gq_ff;
      blocked_in   = blocked_ff;
      unblock_in   = unblock_ff;
      pkt_in       = pkt_ff;
      new_in       = new_ff;
      owner_vld_in = owner_vld_ff;
      owner_id_in  = owner_id_ff;
      seen_in      = seen_ff;
      nz_in        = nz_ff;
      rc_re        = 1'b0;
      rc_we        = 1'b0;
      rc_addr      = qidx;
      rc_wdata     = rc_rd_ff;
      pend_cmd     = '0;
      pend_cmd.qid = q_ff;
      load_rsp     = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_accept) begin
               kind_in    = kind_type'(req_kind);
               q_in       = req_queue_id;
               status_in  = ST_OK;
               granted_in = 1'b0;
               gq_in      = '0;
               blocked_in = 1'b0;
               unblock_in = 1'b0;
               pkt_in     = '0;
               new_in     = 1'b0;
               state_in   = S_DECODE;
            end
         end
         S_DECODE: begin
            state_in = S_RESP;
            if (in_range) begin
               unique case (kind_ff)
                  KIND_DISPATCH: begin
                     // A full FIFO drops the request but still reports the barrier
                     // packets and marks the queue as seen.
                     if (enable_ff) begin
                        pkt_in        = BARRIER_PACKETS;
                        new_in        = !seen_ff[qidx];
                        seen_in[qidx] = 1'b1;
                        if (pend_stat.full) begin
                           status_in = ST_FULL;
                        end else begin
                           pend_cmd.append = 1'b1;
                        end
                     end
                  end
                  KIND_READY: begin
                     if (enable_ff) begin
                        state_in = S_RC_RD;
                     end
                  end
                  KIND_COMPLETE: begin
                     // A completion always blocks the finishing queue and hands
                     // execution to the oldest ready pending queue, if there is one.
                     if (enable_ff) begin
                        if (!owner_vld_ff) begin
                           status_in = ST_NO_OWNER;
                        end
                        blocked_in          = 1'b1;
                        pend_cmd.search     = 1'b1;
                        pend_cmd.grant_mode = 1'b1;
                        state_in            = S_SEARCH;
                     end
                  end
                  KIND_DESTROY: begin
                     // Destroy purges the queue even with serialization off, and an
                     // owning queue keeps ownership.
                     unblock_in    = 1'b1;
                     seen_in[qidx] = 1'b0;
                     nz_in[qidx]   = 1'b0;
                     if (owner_vld_ff && (owner_id_ff == q_ff)) begin
                        status_in = ST_DESTROY_OWNING;
                     end
                     pend_cmd.search = 1'b1;
                     state_in        = S_SEARCH;
                  end
                  default: begin
                     state_in = S_RESP;
                  end
               endcase
            end
         end
         S_RC_RD: begin
            rc_re    = 1'b1;
            state_in = S_RC_WR;
         end
         S_RC_WR: begin
            // The count saturates at its maximum.
            if (rc_cur != RC_MAX) begin
               rc_we       = 1'b1;
               rc_wdata    = rc_cur + RC_W'(1);
               nz_in[qidx] = 1'b1;
            end
            if (!owner_vld_ff) begin
               pend_cmd.search     = 1'b1;
               pend_cmd.grant_mode = 1'b1;
               state_in            = S_SEARCH;
            end else begin
               state_in = S_RESP;
            end
         end
         S_SEARCH: begin
            if (pend_stat.done) begin
               state_in = S_RESP;
               if (kind_ff == KIND_DESTROY) begin
                  if (pend_stat.found && (status_ff != ST_DESTROY_OWNING)) begin
                     status_in = ST_DESTROY_PENDING;
                  end
               end else if (pend_stat.found) begin
                  granted_in   = 1'b1;
                  gq_in        = pend_stat.found_q;
                  owner_vld_in = 1'b1;
                  owner_id_in  = pend_stat.found_q;
                  state_in     = S_DEC_RD;
               end else if (kind_ff == KIND_COMPLETE) begin
                  // Nothing ready to run: execution goes back to no owner.
                  owner_vld_in = 1'b0;
                  owner_id_in  = '0;
               end
            end
         end
         S_DEC_RD: begin
            rc_re    = 1'b1;
            rc_addr  = gidx;
            state_in = S_DEC_WR;
         end
         S_DEC_WR: begin
            // The granted queue had a nonzero count, so the memory value is live.
            rc_we       = 1'b1;
            rc_addr     = gidx;
            rc_wdata    = rc_rd_ff - RC_W'(1);
            nz_in[gidx] = (rc_rd_ff != RC_W'(1));
            state_in    = S_RESP;
         end
         S_RESP: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               load_rsp = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (load_rsp) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (rc_we) begin
         rc_mem_ff[rc_addr] <= rc_wdata;
      end
      if (rc_re) begin
         rc_rd_ff <= rc_mem_ff[rc_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         enable_ff    <= 1'b0;
         owner_vld_ff <= 1'b0;
         owner_id_ff  <= '0;
         seen_ff      <= '0;
         nz_ff        <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         if (csr_wr_en) begin
            enable_ff <= csr_wr_data;
         end
         owner_vld_ff <= owner_vld_in;
         owner_id_ff  <= owner_id_in;
         seen_ff      <= seen_in;
         nz_ff        <= nz_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff    <= kind_in;
      q_ff       <= q_in;
      status_ff  <= status_in;
      granted_ff <= granted_in;
      gq_ff      <= gq_in;
      blocked_ff <= blocked_in;
      unblock_ff <= unblock_in;
      pkt_ff     <= pkt_in;
      new_ff     <= new_in;
      if (load_rsp) begin
         rsp_status_ff    <= status_ff;
         rsp_granted_ff   <= granted_ff;
         rsp_gq_ff        <= gq_ff;
         rsp_blocked_ff   <= blocked_ff;
         rsp_unblock_ff   <= unblock_ff;
         rsp_pkt_ff       <= pkt_ff;
         rsp_new_ff       <= new_ff;
         rsp_owner_vld_ff <= owner_vld_ff;
         rsp_owner_id_ff  <= owner_id_ff;
      end
   end

   assign rsp_valid             = rsp_valid_ff;
   assign rsp_status            = rsp_status_ff;
   assign rsp_granted           = rsp_granted_ff;
   assign rsp_granted_queue     = rsp_gq_ff;
   assign rsp_blocked           = rsp_blocked_ff;
   assign rsp_unblock_destroyed = rsp_unblock_ff;
   assign rsp_packet_count      = rsp_pkt_ff;
   assign rsp_new_queue         = rsp_new_ff;
   assign rsp_owner_valid       = rsp_owner_vld_ff;
   assign rsp_owner_queue       = rsp_owner_id_ff;

   // A granted queue is the owner reported with the same response.
   a_grant_owner: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_granted |-> rsp_owner_valid && (rsp_owner_queue == rsp_granted_queue))
      else $error("granted queue is not the reported owner");

   // A completion either hands execution on or leaves no owner behind.
   a_block_outcome: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_blocked |-> rsp_granted || !rsp_owner_valid)
      else $error("completion left a stale owner");

   // Without an owner the owner id reads as zero.
   a_owner_clear: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_owner_valid |-> (rsp_owner_queue == '0))
      else $error("owner id not cleared with ownership");

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for the ready-gated FIFO grant arbiter, with a scoreboard class.
module testbench;
   import rgfa_pkg::*;

   localparam int CLOCK_HALF  = 4;
   localparam int NUM_Q       = NUM_QUEUES_DEF;
   localparam int DEPTH       = FIFO_DEPTH_DEF;
   localparam int COUNT_MAX   = READY_COUNT_MAX_DEF;
   // Percentage of cycles in which either side idles while idling is on.
   localparam int IDLE_PCT    = 7;
   // Length of the long receiver hold-off that backs the arbiter up.
   localparam int HOLD_CYCLES = 300;
   // The long receiver hold-off dominates the limit.
   localparam int QUIET_LIMIT = 4000;
   // Cycles allowed after the last response for anything stray to show up.
   localparam int TAIL_CYCLES = DEPTH + 12;
   localparam int REPORT_MAX  = 10;

   // One response of the arbiter, in port order so that a concatenation of the ports fills it.
   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic                granted;
      logic [QID_W-1:0]    granted_queue;
      logic                blocked;
      logic                unblock_destroyed;
      logic [PKT_W-1:0]    packet_count;
      logic                new_queue;
      logic                owner_valid;
      logic [QID_W-1:0]    owner_queue;
   } grant_result_type;

   // The scoreboard keeps its own copy of the arbiter state. Every accepted request is
   // played against that copy, and the response it should produce is queued in order.
   class arbiter_scoreboard;
      bit               serialize;
      logic [QID_W-1:0] pending[$];
      int unsigned      ready_cnt[NUM_Q];
      bit               seen[NUM_Q];
      bit               owner_present;
      logic [QID_W-1:0] owner_id;
      grant_result_type awaited[$];
      int unsigned      mismatches;

      function new();
         serialize     = 1'b0;
         owner_present = 1'b0;
         owner_id      = '0;
         mismatches    = 0;
         for (int i = 0; i < NUM_Q; i++) begin
            ready_cnt[i] = 0;
            seen[i]      = 1'b0;
         end
      endfunction

      // Hand execution to the oldest pending queue that has a ready count left.
      function bit grant_oldest(output logic [QID_W-1:0] who);
         who = '0;
         for (int i = 0; i < pending.size(); i++) begin
            if (ready_cnt[pending[i]] > 0) begin
               who = pending[i];
               pending.delete(i);
               ready_cnt[who]--;
               owner_present = 1'b1;
               owner_id      = who;
               return 1'b1;
            end
         end
         return 1'b0;
      endfunction

      function void note_request(kind_type kind, logic [QID_W-1:0] q);
         grant_result_type r;
         logic [QID_W-1:0] who;
         int               pos;
         r = '0;
         case (kind)
            KIND_DISPATCH: if (serialize) begin
               r.packet_count = BARRIER_PACKETS;
               r.new_queue    = !seen[q];
               seen[q]        = 1'b1;
               if (pending.size() < DEPTH)
                  pending = {pending, q};
               else
                  r.status = ST_FULL;
            end
            KIND_READY: if (serialize) begin
               if (ready_cnt[q] < COUNT_MAX)
                  ready_cnt[q]++;
               if (!owner_present && grant_oldest(who)) begin
                  r.granted       = 1'b1;
                  r.granted_queue = who;
               end
            end
            KIND_COMPLETE: if (serialize) begin
               if (!owner_present)
                  r.status = ST_NO_OWNER;
               r.blocked = 1'b1;
               if (grant_oldest(who)) begin
                  r.granted       = 1'b1;
                  r.granted_queue = who;
               end else begin
                  owner_present = 1'b0;
                  owner_id      = '0;
               end
            end
            default: begin
               // A destroy purges the queue whether or not serialization is on.
               r.unblock_destroyed = 1'b1;
               pos = -1;
               for (int i = 0; i < pending.size() && pos < 0; i++)
                  if (pending[i] == q)
                     pos = i;
               if (pos >= 0)
                  pending.delete(pos);
               ready_cnt[q] = 0;
               seen[q]      = 1'b0;
               if (owner_present && owner_id == q)
                  r.status = ST_DESTROY_OWNING;
               else if (pos >= 0)
                  r.status = ST_DESTROY_PENDING;
            end
         endcase
         r.owner_valid = owner_present;
         r.owner_queue = owner_present ? owner_id : '0;
         awaited = {awaited, r};
      endfunction

      function string describe(grant_result_type r);
         return $sformatf({"status %0d granted %0b queue %0d blocked %0b unblock %0b ",
                           "packets %0d new %0b owner %0b/%0d"},
                          r.status, r.granted, r.granted_queue, r.blocked,
                          r.unblock_destroyed, r.packet_count, r.new_queue,
                          r.owner_valid, r.owner_queue);
      endfunction

      function void check_response(grant_result_type got);
         grant_result_type want;
         if (awaited.size() == 0) begin
            mismatches++;
            if (mismatches <= REPORT_MAX)
               $display("%0t: response with no request waiting: %s", $realtime, describe(got));
            return;
         end
         want = awaited[0];
         awaited.delete(0);
         if (got !== want) begin
            mismatches++;
            if (mismatches <= REPORT_MAX) begin
               $display("%0t: response mismatch", $realtime);
               $display("   expected %s", describe(want));
               $display("   actual   %s", describe(got));
            end
         end
      endfunction
   endclass

   logic                clock;
   logic                reset;
   logic                csr_wr_en;
   logic                csr_wr_data;
   logic                req_valid;
   logic                req_stall;
   logic [KIND_W-1:0]   req_kind;
   logic [QID_W-1:0]    req_queue_id;
   logic                rsp_valid;
   logic                rsp_stall;
   logic [STATUS_W-1:0] rsp_status;
   logic                rsp_granted;
   logic [QID_W-1:0]    rsp_granted_queue;
   logic                rsp_blocked;
   logic                rsp_unblock_destroyed;
   logic [PKT_W-1:0]    rsp_packet_count;
   logic                rsp_new_queue;
   logic                rsp_owner_valid;
   logic [QID_W-1:0]    rsp_owner_queue;

   arbiter_scoreboard sb;

   // Idling of both sides is switched off for one long stretch of the run.
   bit idle_on = 1'b1;
   // Raised once by the stimulus to make the receiver hold off for a long stretch.
   bit hold_req = 1'b0;
   // Position of each queue in its dispatch, ready, completion life cycle.
   int flow_step[NUM_Q];
   int quiet_cycles = 0;

   ready_gated_fifo_grant_arbiter i_dut (
      .clock                 (clock),
      .reset                 (reset),
      .csr_wr_en             (csr_wr_en),
      .csr_wr_data           (csr_wr_data),
      .req_valid             (req_valid),
      .req_stall             (req_stall),
      .req_kind              (req_kind),
      .req_queue_id          (req_queue_id),
      .rsp_valid             (rsp_valid),
      .rsp_stall             (rsp_stall),
      .rsp_status            (rsp_status),
      .rsp_granted           (rsp_granted),
      .rsp_granted_queue     (rsp_granted_queue),
      .rsp_blocked           (rsp_blocked),
      .rsp_unblock_destroyed (rsp_unblock_destroyed),
      .rsp_packet_count      (rsp_packet_count),
      .rsp_new_queue         (rsp_new_queue),
      .rsp_owner_valid       (rsp_owner_valid),
      .rsp_owner_queue       (rsp_owner_queue)
   );

   always #CLOCK_HALF clock = ~clock;

   // Responses are sampled at the rising edge, where every input driven at the falling
   // edge is stable. The same process runs the watchdog: it counts cycles in which
   // neither channel moves a request or a response and gives up at the limit.
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         sb.check_response({rsp_status, rsp_granted, rsp_granted_queue, rsp_blocked,
                            rsp_unblock_destroyed, rsp_packet_count, rsp_new_queue,
                            rsp_owner_valid, rsp_owner_queue});
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("simulation failed");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // Receiver: stalls at random, or for a long counted stretch when asked to.
   initial begin : receiver
      int hold_left;
      hold_left = 0;
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_req) begin
            hold_req  = 1'b0;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= idle_on && ($urandom_range(99) < IDLE_PCT);
         end
      end
   end

   // Offer one request and hold it until the arbiter takes it. Called and returning at a
   // falling edge. Valid stays high into the next request unless an idle gap is drawn.
   task automatic send_request(kind_type kind, logic [QID_W-1:0] q);
      int gap;
      if (idle_on && $urandom_range(99) < IDLE_PCT) begin
         gap = $urandom_range(1, 6);
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid    <= 1'b1;
      req_kind     <= kind;
      req_queue_id <= q;
      @(posedge clock);
      while (req_stall)
         @(posedge clock);
      sb.note_request(kind, q);
      @(negedge clock);
   endtask

   // Stop offering and wait until every accepted request has been answered. The task always
   // waits for a falling edge, so valid is never lowered and raised in the same time step.
   task automatic wait_all_results();
      req_valid <= 1'b0;
      do
         @(negedge clock);
      while (sb.awaited.size() != 0);
   endtask

   // The register is only written while nothing is in flight.
   task automatic write_serialize(logic value);
      wait_all_results();
      repeat (4) @(negedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(negedge clock);
      csr_wr_en   <= 1'b0;
      sb.serialize = value;
   endtask

   // Mostly well-formed life cycles on a few active queues, so that grants, blocking and
   // hand-overs happen often; the rest is random noise over all kinds and ids.
   task automatic send_random_traffic(int count);
      kind_type         kind;
      logic [QID_W-1:0] q;
      logic [QID_W-1:0] active[4];
      for (int n = 0; n < count; n++) begin
         if (n % 64 == 0)
            for (int a = 0; a < 4; a++)
               active[a] = QID_W'($urandom_range(NUM_Q - 1));
         if ($urandom_range(99) < 20) begin
            kind = kind_type'($urandom_range(3));
            q    = QID_W'($urandom_range(NUM_Q - 1));
         end else begin
            q = active[$urandom_range(3)];
            case (flow_step[q])
               0:       kind = KIND_DISPATCH;
               1:       kind = KIND_READY;
               default: kind = KIND_COMPLETE;
            endcase
            if ($urandom_range(99) < 4)
               kind = KIND_DESTROY;
            flow_step[q] = (flow_step[q] + 1) % 3;
         end
         send_request(kind, q);
      end
   endtask

   initial begin : stimulus
      sb           = new();
      clock        = 1'b0;
      reset        = 1'b1;
      csr_wr_en    = 1'b0;
      csr_wr_data  = 1'b0;
      req_valid    = 1'b0;
      req_kind     = KIND_DISPATCH;
      req_queue_id = '0;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Serialization is off after reset: only the destroy does any work.
      send_request(KIND_DISPATCH, 4'd15);
      send_request(KIND_READY, 4'd0);
      send_request(KIND_COMPLETE, 4'd5);
      send_request(KIND_DESTROY, 4'd3);

      write_serialize(1'b1);
      // A completion with no owner, then dispatches of new and already seen queues.
      send_request(KIND_COMPLETE, 4'd0);
      send_request(KIND_DISPATCH, 4'd0);
      send_request(KIND_DISPATCH, 4'd15);
      send_request(KIND_DISPATCH, 4'd0);
      // The oldest entry is not ready yet, so the grant skips it to queue 15.
      send_request(KIND_READY, 4'd15);
      // With an owner in place a ready only raises the count.
      send_request(KIND_READY, 4'd0);
      // Destroying the owner keeps ownership and reports it.
      send_request(KIND_DESTROY, 4'd15);
      // The completion hands execution to queue 0.
      send_request(KIND_COMPLETE, 4'd15);
      // Queue 0 both owns and is still pending: ownership wins in the status.
      send_request(KIND_DESTROY, 4'd0);
      send_request(KIND_DISPATCH, 4'd7);
      send_request(KIND_DESTROY, 4'd7);
      // Completion from a queue that does not own execution, with nothing left to grant.
      send_request(KIND_COMPLETE, 4'd9);
      send_request(KIND_READY, 4'd3);

      // Overfill the pending FIFO so that dispatches get dropped, then purge it.
      for (int n = 0; n < DEPTH + 3; n++)
         send_request(KIND_DISPATCH, QID_W'($urandom_range(NUM_Q - 1)));
      while (sb.pending.size() != 0)
         send_request(KIND_DESTROY, sb.pending[0]);

      // Give queue 5 ownership, then push the ready count of queue 9 past its ceiling.
      send_request(KIND_COMPLETE, 4'd5);
      send_request(KIND_DISPATCH, 4'd5);
      send_request(KIND_READY, 4'd5);
      repeat (COUNT_MAX + 3)
         send_request(KIND_READY, 4'd9);
      send_request(KIND_DISPATCH, 4'd9);
      send_request(KIND_DISPATCH, 4'd9);
      send_request(KIND_COMPLETE, 4'd5);
      send_request(KIND_COMPLETE, 4'd9);
      send_request(KIND_DESTROY, 4'd9);

      send_random_traffic(500);

      // A long stretch in which neither side idles.
      idle_on = 1'b0;
      send_random_traffic(300);
      idle_on = 1'b1;

      // The receiver holds off while requests keep coming, so the arbiter backs up and
      // stalls its input; afterwards the sender pauses until everything has drained.
      hold_req = 1'b1;
      send_random_traffic(40);
      wait_all_results();
      send_random_traffic(200);

      write_serialize(1'b0);
      send_random_traffic(150);

      write_serialize(1'b1);
      send_random_traffic(300);

      wait_all_results();
      repeat (TAIL_CYCLES) @(negedge clock);
      if (sb.mismatches == 0 && sb.awaited.size() == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

endmodule
